>>> hdl/imusfp_pkg.sv
// Shared constants, types and CRC helper for the IMU serial frame parser.
package imusfp_pkg;

    localparam int BUFFER_BYTES_DEF = 64;
    localparam int MAX_RESULTS      = 29;
    localparam int RES_W            = $clog2(MAX_RESULTS + 1);
    localparam int CFG_DATA_W       = 8;
    localparam int CFG_INDEX_W      = 1;

    localparam logic [7:0]  SYNC_BYTE       = 8'h55;
    localparam logic [7:0]  READ_FUNCTION   = 8'h03;
    localparam int          NORMAL_LEN      = 11;
    localparam int          SUM_LEN         = 10;
    localparam int          MODBUS_OVERHEAD = 5;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;

    localparam logic [CFG_INDEX_W-1:0] REG_PROTOCOL_MODE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_START    = 1'b1;

    localparam logic KIND_NORMAL = 1'b0;
    localparam logic KIND_MODBUS = 1'b1;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_MODBUS = 2'd1,
        MODE_CAN    = 2'd2,
        MODE_I2C    = 2'd3
    } mode_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_NPUT = 6'b000100,
        S_EMA  = 6'b001000,
        S_EMB  = 6'b010000,
        S_EMC  = 6'b100000
    } state_t;

    // CRC-16/MODBUS update over one byte, reflected
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> hdl/imusfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module imusfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/imu_serial_frame_parser.sv
// Each byte is stored in the buffer RAM, then the held bytes are scanned, one per cycle.
// Normal mode: a full 11-byte frame is checked once held, then it waits for a free output.
// Modbus mode: no scan while 2 or fewer bytes are held, then a scan up to the byte count
// until it is met, a full scan to check the CRC, then S_EMA, S_EMB, S_EMC per register word.
// CAN/I2C modes: bytes are dropped. Throughput is set by the single read port of the buffer RAM.
// Reset clears fill count, head pointer, config and output valid; buffer RAM is not cleared.
module imu_serial_frame_parser
    import imusfp_pkg::*;
#(
    parameter int BUFFER_BYTES = imusfp_pkg::BUFFER_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [imusfp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [imusfp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         data_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               kind,
    output logic [7:0]                         type_code,
    output logic [15:0]                        word0,
    output logic [15:0]                        word1,
    output logic [15:0]                        word2,
    output logic [15:0]                        word3,
    output logic [8:0]                         reg_index,
    output logic [15:0]                        reg_value,
    output logic                               last
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int SW = CW + 1;
    localparam int OW = RES_W + 2;

    function automatic logic [AW-1:0] buf_addr(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(BUFFER_BYTES))
        begin
            s = s - SW'(BUFFER_BYTES);
        end
        return s[AW-1:0];
    endfunction

    state_t           state_reg, state_next;
    mode_t            mode_reg, mode_next;
    logic [7:0]       rstart_reg, rstart_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic [CW-1:0]    issue_reg, issue_next;
    logic             pend_reg, pend_next;
    logic [CW-1:0]    ppos_reg, ppos_next;
    logic [CW-1:0]    lastpos_reg, lastpos_next;
    logic [RES_W-1:0] wi_reg, wi_next;
    logic [RES_W-1:0] words_reg, words_next;
    logic             out_valid_reg, out_valid_next;

    logic [7:0]       sum_reg;
    logic [15:0]      crc_reg;
    logic [7:0]       count_reg;
    logic [7:0]       hi_reg;
    logic [7:0]       cap_reg [1:9];
    logic             kind_reg;
    logic [7:0]       type_reg;
    logic [15:0]      word_reg [0:3];
    logic [8:0]       ridx_reg;
    logic [15:0]      rval_reg;
    logic             last_reg;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [7:0]       ram_rdata;

    logic [CW-1:0]    fill_eff, fill_inc, fill_m2, fill_m1;
    logic             out_free;
    logic             sum_init, sum_en, crc_init, crc_en, count_en, cap_en, hi_en;
    logic             ld_norm, ld_mb;
    logic [9:0]       need_len;
    logic [6:0]       half_count;
    logic [OW-1:0]    off_hi, off_lo;

    imusfp_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_BYTES)
    ) u_buf (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(data_byte),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign out_free   = !out_valid_reg || out_ready;
    assign fill_eff   = (fill_reg == CW'(BUFFER_BYTES)) ? '0 : fill_reg;
    assign fill_inc   = fill_eff + CW'(1);
    assign fill_m2    = fill_reg - CW'(2);
    assign fill_m1    = fill_reg - CW'(1);
    assign need_len   = {2'b00, ram_rdata} + 10'(MODBUS_OVERHEAD);
    assign half_count = count_reg[7:1];
    assign off_hi     = {1'b0, wi_reg, 1'b0} + OW'(3);
    assign off_lo     = {1'b0, wi_reg, 1'b0} + OW'(4);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        rstart_next    = rstart_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        ppos_next      = issue_reg;
        lastpos_next   = lastpos_reg;
        wi_next        = wi_reg;
        words_next     = words_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ram_we         = 1'b0;
        ram_waddr      = buf_addr(head_reg, fill_eff);
        ram_re         = 1'b0;
        ram_raddr      = buf_addr(head_reg, issue_reg);
        sum_init       = 1'b0;
        sum_en         = 1'b0;
        crc_init       = 1'b0;
        crc_en         = 1'b0;
        count_en       = 1'b0;
        cap_en         = 1'b0;
        hi_en          = 1'b0;
        ld_norm        = 1'b0;
        ld_mb          = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_PROTOCOL_MODE: mode_next   = mode_t'(cfg_data[1:0]);
                REG_READ_START:    rstart_next = cfg_data[7:0];
                default:           ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ram_we     = 1'b1;
                    fill_next  = fill_inc;
                    issue_next = '0;
                    sum_init   = 1'b1;
                    crc_init   = 1'b1;
                    case (mode_reg)
                        MODE_NORMAL:
                        begin
                            lastpos_next = (fill_inc >= CW'(NORMAL_LEN)) ? CW'(SUM_LEN) : '0;
                            state_next   = S_SCAN;
                        end
                        MODE_MODBUS:
                        begin
                            lastpos_next = fill_inc - CW'(1);
                            if (fill_inc > CW'(2))
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            fill_next = '0;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (issue_reg <= lastpos_reg)
                begin
                    ram_re     = 1'b1;
                    pend_next  = 1'b1;
                    issue_next = issue_reg + CW'(1);
                end
                if (pend_reg)
                begin
                    if (mode_reg == MODE_NORMAL)
                    begin
                        sum_en = (ppos_reg < CW'(SUM_LEN));
                        cap_en = (ppos_reg >= CW'(1)) && (ppos_reg < CW'(SUM_LEN));
                        if (ppos_reg == '0 && ram_rdata != SYNC_BYTE)
                        begin
                            head_next  = buf_addr(head_reg, CW'(1));
                            fill_next  = fill_m1;
                            state_next = S_IDLE;
                        end
                        else if (ppos_reg == CW'(SUM_LEN))
                        begin
                            if (sum_reg != ram_rdata)
                            begin
                                head_next  = buf_addr(head_reg, CW'(1));
                                fill_next  = fill_m1;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                state_next = S_NPUT;
                            end
                        end
                        else if (ppos_reg == lastpos_reg)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        crc_en   = (ppos_reg < fill_m2);
                        count_en = (ppos_reg == CW'(2));
                        if (ppos_reg == CW'(1) && ram_rdata != READ_FUNCTION)
                        begin
                            head_next  = buf_addr(head_reg, CW'(1));
                            fill_next  = fill_m1;
                            state_next = S_IDLE;
                        end
                        else if (ppos_reg == CW'(2) && 10'(fill_reg) < need_len)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (ppos_reg > CW'(2) &&
                                 ((ppos_reg == fill_m2 && crc_reg[7:0] != ram_rdata) ||
                                  (ppos_reg == fill_m1 && crc_reg[15:8] != ram_rdata)))
                        begin
                            head_next  = buf_addr(head_reg, CW'(1));
                            fill_next  = fill_m1;
                            state_next = S_IDLE;
                        end
                        else if (ppos_reg == fill_m1)
                        begin
                            wi_next = '0;
                            if (half_count > 7'(MAX_RESULTS))
                            begin
                                words_next = RES_W'(MAX_RESULTS);
                            end
                            else
                            begin
                                words_next = half_count[RES_W-1:0];
                            end
                            if (half_count == '0)
                            begin
                                fill_next  = '0;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                state_next = S_EMA;
                            end
                        end
                    end
                end
            end

            S_NPUT:
            begin
                if (out_free)
                begin
                    ld_norm        = 1'b1;
                    out_valid_next = 1'b1;
                    fill_next      = '0;
                    state_next     = S_IDLE;
                end
            end

            S_EMA:
            begin
                ram_re     = 1'b1;
                ram_raddr  = buf_addr(head_reg, CW'(off_hi));
                state_next = S_EMB;
            end

            S_EMB:
            begin
                hi_en      = 1'b1;
                ram_re     = 1'b1;
                ram_raddr  = buf_addr(head_reg, CW'(off_lo));
                state_next = S_EMC;
            end

            S_EMC:
            begin
                if (out_free)
                begin
                    ld_mb          = 1'b1;
                    out_valid_next = 1'b1;
                    if (wi_reg == words_reg - RES_W'(1))
                    begin
                        fill_next  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        wi_next    = wi_reg + RES_W'(1);
                        state_next = S_EMA;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_NORMAL;
            rstart_reg    <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            ppos_reg      <= '0;
            lastpos_reg   <= '0;
            wi_reg        <= '0;
            words_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            rstart_reg    <= rstart_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            ppos_reg      <= ppos_next;
            lastpos_reg   <= lastpos_next;
            wi_reg        <= wi_next;
            words_reg     <= words_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_init)
        begin
            sum_reg <= '0;
        end
        else if (sum_en)
        begin
            sum_reg <= sum_reg + ram_rdata;
        end
        if (crc_init)
        begin
            crc_reg <= CRC_INIT;
        end
        else if (crc_en)
        begin
            crc_reg <= crc16_byte(crc_reg, ram_rdata);
        end
        if (count_en)
        begin
            count_reg <= ram_rdata;
        end
        if (cap_en)
        begin
            cap_reg[ppos_reg[3:0]] <= ram_rdata;
        end
        if (hi_en)
        begin
            hi_reg <= ram_rdata;
        end
        if (ld_norm)
        begin
            kind_reg    <= KIND_NORMAL;
            type_reg    <= cap_reg[1];
            word_reg[0] <= {cap_reg[3], cap_reg[2]};
            word_reg[1] <= {cap_reg[5], cap_reg[4]};
            word_reg[2] <= {cap_reg[7], cap_reg[6]};
            word_reg[3] <= {cap_reg[9], cap_reg[8]};
            ridx_reg    <= '0;
            rval_reg    <= '0;
            last_reg    <= 1'b1;
        end
        else if (ld_mb)
        begin
            kind_reg    <= KIND_MODBUS;
            type_reg    <= '0;
            word_reg[0] <= '0;
            word_reg[1] <= '0;
            word_reg[2] <= '0;
            word_reg[3] <= '0;
            ridx_reg    <= 9'(rstart_reg) + 9'(wi_reg);
            rval_reg    <= {hi_reg, ram_rdata};
            last_reg    <= (wi_reg == words_reg - RES_W'(1));
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign type_code = type_reg;
    assign word0     = word_reg[0];
    assign word1     = word_reg[1];
    assign word2     = word_reg[2];
    assign word3     = word_reg[3];
    assign reg_index = ridx_reg;
    assign reg_value = rval_reg;
    assign last      = last_reg;

endmodule

>>> tb/imu_serial_frame_parser_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for imu_serial_frame_parser: queue-fed driver, predictor, monitor.
module imu_serial_frame_parser_test;
    import imusfp_pkg::*;

    localparam int BUF_BYTES    = BUFFER_BYTES_DEF;
    localparam int SETTLE       = 160;
    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_BYTES = 180;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_CFG,
        OP_DRAIN
    } plan_op_t;

    typedef struct {
        plan_op_t               op;
        logic [CFG_INDEX_W-1:0] index;
        logic [7:0]             value;
        int                     gap;
    } plan_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  type_code;
        logic [15:0] word0;
        logic [15:0] word1;
        logic [15:0] word2;
        logic [15:0] word3;
        logic [8:0]  reg_index;
        logic [15:0] reg_value;
        logic        last;
    } parsed_rec_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [7:0]             data_byte = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   kind;
    logic [7:0]             type_code;
    logic [15:0]            word0;
    logic [15:0]            word1;
    logic [15:0]            word2;
    logic [15:0]            word3;
    logic [8:0]             reg_index;
    logic [15:0]            reg_value;
    logic                   last;

    imu_serial_frame_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .type_code (type_code),
        .word0     (word0),
        .word1     (word1),
        .word2     (word2),
        .word3     (word3),
        .reg_index (reg_index),
        .reg_value (reg_value),
        .last      (last)
    );

    always #4 clk = ~clk;

    plan_item_t  tx_plan[$];
    parsed_rec_t expected_records[$];

    logic [7:0] shadow_buf [BUF_BYTES];
    int         shadow_fill  = 0;
    mode_t      shadow_mode  = MODE_NORMAL;
    logic [7:0] shadow_start = 8'h00;

    bit burst         = 1'b0;
    int bytes_planned = 0;
    int mismatches    = 0;
    bit stim_done     = 1'b0;

    // CRC-16/MODBUS, one byte, LSB first
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        lsb;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            lsb = c[0];
            c   = {1'b0, c[15:1]};
            if (lsb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic void shift_out_oldest();
        if (shadow_fill == 0)
            return;
        shadow_fill--;
        for (int i = 0; i < shadow_fill; i++)
            shadow_buf[i] = shadow_buf[i + 1];
    endfunction

    function automatic void apply_write(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] v);
        case (idx)
            REG_PROTOCOL_MODE: shadow_mode = mode_t'(v[1:0]);
            REG_READ_START:    shadow_start = v;
            default: ;
        endcase
    endfunction

    // Appends one byte to the shadow buffer and queues the records it produces
    function automatic void parse_byte(input logic [7:0] b);
        logic [7:0]  sum;
        logic [15:0] crc;
        int          cnt;
        int          nwords;
        parsed_rec_t r;
        if (shadow_fill >= BUF_BYTES)
            shadow_fill = 0;
        shadow_buf[shadow_fill] = b;
        shadow_fill++;
        case (shadow_mode)
            MODE_NORMAL:
            begin
                if (shadow_buf[0] != SYNC_BYTE)
                    shift_out_oldest();
                else if (shadow_fill >= NORMAL_LEN)
                begin
                    sum = 8'h00;
                    for (int i = 0; i < SUM_LEN; i++)
                        sum = sum + shadow_buf[i];
                    if (sum != shadow_buf[SUM_LEN])
                        shift_out_oldest();
                    else
                    begin
                        r           = '0;
                        r.kind      = KIND_NORMAL;
                        r.type_code = shadow_buf[1];
                        r.word0     = {shadow_buf[3], shadow_buf[2]};
                        r.word1     = {shadow_buf[5], shadow_buf[4]};
                        r.word2     = {shadow_buf[7], shadow_buf[6]};
                        r.word3     = {shadow_buf[9], shadow_buf[8]};
                        r.last      = 1'b1;
                        expected_records.push_back(r);
                        shadow_fill = 0;
                    end
                end
            end
            MODE_MODBUS:
            begin
                if (shadow_fill > 2)
                begin
                    cnt = int'(shadow_buf[2]);
                    if (shadow_buf[1] != READ_FUNCTION)
                        shift_out_oldest();
                    else if (shadow_fill >= cnt + MODBUS_OVERHEAD)
                    begin
                        crc = CRC_INIT;
                        for (int i = 0; i < shadow_fill - 2; i++)
                            crc = crc_step(crc, shadow_buf[i]);
                        if (crc[7:0] != shadow_buf[shadow_fill - 2] ||
                            crc[15:8] != shadow_buf[shadow_fill - 1])
                            shift_out_oldest();
                        else
                        begin
                            nwords = cnt / 2;
                            if (nwords > MAX_RESULTS)
                                nwords = MAX_RESULTS;
                            for (int i = 0; i < nwords; i++)
                            begin
                                r           = '0;
                                r.kind      = KIND_MODBUS;
                                r.reg_index = 9'(int'(shadow_start) + i);
                                r.reg_value = {shadow_buf[2 * i + 3], shadow_buf[2 * i + 4]};
                                r.last      = (i == nwords - 1);
                                expected_records.push_back(r);
                            end
                            shadow_fill = 0;
                        end
                    end
                end
            end
            default: shadow_fill = 0;
        endcase
        if (shadow_fill >= BUF_BYTES)
            shadow_fill = 0;
    endfunction

    function automatic void queue_byte(input logic [7:0] b);
        plan_item_t s;
        s.op    = OP_BYTE;
        s.index = '0;
        s.value = b;
        s.gap   = burst ? 0 : int'($urandom_range(0, 4));
        tx_plan.push_back(s);
        bytes_planned++;
    endfunction

    function automatic void queue_write(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] v);
        plan_item_t s;
        s.op    = OP_CFG;
        s.index = idx;
        s.value = v;
        s.gap   = 0;
        tx_plan.push_back(s);
    endfunction

    function automatic void queue_drain();
        plan_item_t s;
        s.op    = OP_DRAIN;
        s.index = '0;
        s.value = 8'h00;
        s.gap   = 0;
        tx_plan.push_back(s);
    endfunction

    // One CAN-mode byte empties the buffer, then the mode is restored
    function automatic void queue_flush(input mode_t back);
        queue_write(REG_PROTOCOL_MODE, {6'b0, MODE_CAN});
        queue_byte(8'($urandom));
        queue_write(REG_PROTOCOL_MODE, {6'b0, back});
    endfunction

    // fill < 0 gives random word bytes
    function automatic void queue_sum_frame(input logic [7:0] type_byte, input int fill,
                                            input bit broken);
        logic [7:0] f[NORMAL_LEN];
        logic [7:0] sum;
        f[0] = SYNC_BYTE;
        f[1] = type_byte;
        sum  = SYNC_BYTE + type_byte;
        for (int i = 2; i < SUM_LEN; i++)
        begin
            f[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
            sum  = sum + f[i];
        end
        f[SUM_LEN] = sum;
        if (broken)
            f[$urandom_range(1, NORMAL_LEN - 1)] ^= 8'(1 << $urandom_range(0, 7));
        for (int i = 0; i < NORMAL_LEN; i++)
            queue_byte(f[i]);
    endfunction

    function automatic void queue_modbus_frame(input int count, input int fill, input bit broken);
        logic [7:0]  f[$];
        logic [15:0] crc;
        f.push_back(8'($urandom));
        f.push_back(READ_FUNCTION);
        f.push_back(8'(count));
        for (int i = 0; i < count; i++)
            f.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
        crc = CRC_INIT;
        foreach (f[i])
            crc = crc_step(crc, f[i]);
        f.push_back(crc[7:0]);
        f.push_back(crc[15:8]);
        if (broken)
            f[$urandom_range(1, f.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
        foreach (f[i])
            queue_byte(f[i]);
    endfunction

    // Driver
    int          settle_count = 0;
    int          gap_left     = 0;
    bit          gap_armed    = 1'b0;
    logic        nxt_valid;
    logic [7:0]  nxt_byte;
    logic        nxt_we;
    logic [CFG_INDEX_W-1:0] nxt_index;
    logic [7:0]  nxt_data;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            data_byte    <= '0;
            cfg_we       <= 1'b0;
            cfg_index    <= '0;
            cfg_data     <= '0;
            settle_count = 0;
        end
        else
        begin
            nxt_valid = in_valid;
            nxt_byte  = data_byte;
            nxt_we    = 1'b0;
            nxt_index = cfg_index;
            nxt_data  = cfg_data;
            if (in_valid && in_ready)
            begin
                parse_byte(data_byte);
                settle_count = 0;
            end
            else if (out_valid && out_ready)
                settle_count = 0;
            else if (settle_count < SETTLE)
                settle_count++;

            if (!(in_valid && !in_ready))
            begin
                nxt_valid = 1'b0;
                if (tx_plan.size() == 0)
                begin
                    if (settle_count >= SETTLE)
                        stim_done = 1'b1;
                end
                else if (tx_plan[0].op == OP_BYTE)
                begin
                    if (!gap_armed)
                    begin
                        gap_left  = tx_plan[0].gap;
                        gap_armed = 1'b1;
                    end
                    if (gap_left > 0)
                        gap_left--;
                    else
                    begin
                        nxt_valid = 1'b1;
                        nxt_byte  = tx_plan[0].value;
                        gap_armed = 1'b0;
                        void'(tx_plan.pop_front());
                    end
                end
                else if (settle_count >= SETTLE && expected_records.size() == 0)
                begin
                    // block idle: register writes and drain points go here
                    if (tx_plan[0].op == OP_CFG)
                    begin
                        nxt_we    = 1'b1;
                        nxt_index = tx_plan[0].index;
                        nxt_data  = tx_plan[0].value;
                        apply_write(tx_plan[0].index, tx_plan[0].value);
                    end
                    void'(tx_plan.pop_front());
                end
            end
            in_valid  <= nxt_valid;
            data_byte <= nxt_byte;
            cfg_we    <= nxt_we;
            cfg_index <= nxt_index;
            cfg_data  <= nxt_data;
        end
    end

    // Monitor
    int hold_left  = 0;
    int eager_left = 0;

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_record();
        parsed_rec_t want;
        if (expected_records.size() == 0)
        begin
            $error("unexpected transaction: kind %0d reg_index %0h", kind, reg_index);
            mismatches++;
        end
        else
        begin
            want = expected_records.pop_front();
            compare_field("kind", 16'(want.kind), 16'(kind));
            compare_field("type_code", 16'(want.type_code), 16'(type_code));
            compare_field("word0", want.word0, word0);
            compare_field("word1", want.word1, word1);
            compare_field("word2", want.word2, word2);
            compare_field("word3", want.word3, word3);
            compare_field("reg_index", 16'(want.reg_index), 16'(reg_index));
            compare_field("reg_value", want.reg_value, reg_value);
            compare_field("last", 16'(want.last), 16'(last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                check_record();
                if (eager_left > 0)
                begin
                    eager_left--;
                    hold_left = 0;
                end
                else
                begin
                    hold_left = $urandom_range(0, 4);
                    if ($urandom_range(0, 15) == 0)
                        eager_left = $urandom_range(10, 40);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("imu_serial_frame_parser_test NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        int         random_target;
        int         nframes;
        int         pick;
        mode_t      phase_mode;
        logic [7:0] v;

        // normal mode straight out of reset
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_sum_frame(8'h00, 0, 1'b0);
        queue_sum_frame(8'hFF, 255, 1'b0);
        queue_sum_frame(8'h51, -1, 1'b1);
        queue_sum_frame(8'h53, -1, 1'b0);
        queue_drain();

        // modbus: odd, zero, bad function, bad CRC
        queue_write(REG_PROTOCOL_MODE, {6'b0, MODE_MODBUS});
        queue_write(REG_READ_START, 8'hFF);
        queue_modbus_frame(4, 255, 1'b0);
        queue_modbus_frame(3, -1, 1'b0);
        queue_modbus_frame(0, -1, 1'b0);
        queue_byte(8'h11);
        queue_byte(8'h06);
        queue_modbus_frame(6, 0, 1'b0);
        queue_modbus_frame(6, -1, 1'b1);
        queue_flush(MODE_MODBUS);

        // largest frame the buffer holds, then one byte too long
        queue_write(REG_READ_START, 8'h00);
        queue_modbus_frame(59, -1, 1'b0);
        queue_modbus_frame(60, -1, 1'b0);
        queue_flush(MODE_MODBUS);

        // mode change with a partial modbus frame held
        queue_byte(SYNC_BYTE);
        queue_byte(READ_FUNCTION);
        queue_byte(8'h04);
        queue_write(REG_PROTOCOL_MODE, {6'b0, MODE_NORMAL});
        queue_sum_frame(8'h52, -1, 1'b0);
        queue_sum_frame(8'h54, -1, 1'b0);

        // discarding modes
        queue_write(REG_PROTOCOL_MODE, {6'b0, MODE_I2C});
        queue_sum_frame(8'h50, -1, 1'b0);
        queue_write(REG_PROTOCOL_MODE, {6'b0, MODE_CAN});
        queue_sum_frame(8'h51, -1, 1'b0);

        random_target = bytes_planned + RANDOM_BYTES;
        while (bytes_planned < random_target)
        begin
            pick = $urandom_range(0, 19);
            phase_mode = (pick < 9) ? MODE_NORMAL :
                         (pick < 17) ? MODE_MODBUS :
                         (pick < 19) ? MODE_CAN : MODE_I2C;
            v = 8'($urandom);
            v[1:0] = phase_mode;
            queue_write(REG_PROTOCOL_MODE, v);
            pick = $urandom_range(0, 5);
            v = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
            queue_write(REG_READ_START, v);
            burst = ($urandom_range(0, 3) == 0);
            nframes = $urandom_range(2, 6);
            for (int f = 0; f < nframes; f++)
            begin
                pick = $urandom_range(0, 9);
                case (phase_mode)
                    MODE_NORMAL:
                    begin
                        if (pick < 7)
                            queue_sum_frame(8'($urandom), -1, 1'b0);
                        else if (pick == 7)
                            queue_sum_frame(8'($urandom), -1, 1'b1);
                        else
                            repeat ($urandom_range(1, 5))
                                queue_byte(($urandom_range(0, 3) == 0) ? SYNC_BYTE
                                                                      : 8'($urandom));
                    end
                    MODE_MODBUS:
                    begin
                        if (pick < 7)
                            queue_modbus_frame(($urandom_range(0, 9) == 0) ?
                                               int'($urandom_range(13, 59)) :
                                               int'($urandom_range(0, 12)), -1, 1'b0);
                        else if (pick == 7)
                        begin
                            queue_modbus_frame($urandom_range(0, 12), -1, 1'b1);
                            if ($urandom_range(0, 1) == 0)
                                queue_flush(MODE_MODBUS);
                        end
                        else
                        begin
                            repeat ($urandom_range(1, 4))
                                queue_byte(($urandom_range(0, 2) == 0) ? READ_FUNCTION
                                                                      : 8'($urandom));
                            queue_flush(MODE_MODBUS);
                        end
                    end
                    default:
                        repeat ($urandom_range(3, 10))
                            queue_byte(8'($urandom));
                endcase
            end
            if ($urandom_range(0, 4) == 0)
                queue_drain();
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait (stim_done);
        if (expected_records.size() != 0)
        begin
            $error("%0d expected transactions never arrived", expected_records.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("imu_serial_frame_parser_test OK");
        else
            $display("imu_serial_frame_parser_test NOT OK");
        $finish;
    end

endmodule
